// ===== hdl/lcdx_pkg.sv =====
`timescale 1ns / 1ps
package lcdx_pkg;

  localparam int MAX_ROWS_DEF    = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [6:0] EXP_ADDR_RST  = 7'd39;
  localparam logic [2:0] ROW_COUNT_RST = 3'd2;

  // expander bit positions
  localparam logic [7:0] BL_BIT = 8'h08;
  localparam logic [7:0] EN_BIT = 8'h04;
  localparam logic [7:0] RS_BIT = 8'h01;

  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_HOME      = 8'h02;

  localparam logic [5:0] WAIT_POWER_MS = 6'd50;
  localparam logic [2:0] WAIT_CMD_MS   = 3'd5;

  // six expander bytes per LCD byte, six commands in the init sequence
  localparam logic [2:0] LAST_STEP     = 3'd5;
  localparam logic [2:0] LAST_INIT_CMD = 3'd5;

  typedef enum logic [2:0] {
    OP_INIT      = 3'd0,
    OP_COMMAND   = 3'd1,
    OP_DATA      = 3'd2,
    OP_CURSOR    = 3'd3,
    OP_CLEAR     = 3'd4,
    OP_HOME      = 3'd5,
    OP_LIGHT_ON  = 3'd6,
    OP_LIGHT_OFF = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    JOB_LCD    = 2'd0,
    JOB_INIT   = 2'd1,
    JOB_SINGLE = 2'd2
  } job_kind_t;

  typedef enum logic {
    REG_EXP_ADDR  = 1'b0,
    REG_ROW_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] value;
    logic       rs;
    logic       bl;
    logic       tail_wait;
  } job_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h33;
      3'd1:    c = 8'h32;
      3'd2:    c = 8'h28;
      3'd3:    c = 8'h0C;
      3'd4:    c = 8'h01;
      default: c = 8'h06;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] b;
    case (r)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h40;
      2'd2:    b = 8'h14;
      default: b = 8'h54;
    endcase
    return b;
  endfunction

endpackage

// ===== hdl/lcdx_front.sv =====
`timescale 1ns / 1ps
module lcdx_front import lcdx_pkg::*; #(
  parameter int MAX_ROWS = MAX_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_opcode,
  input  logic [7:0] in_value,
  input  logic [7:0] in_column,
  input  logic [7:0] in_row,
  input  logic [2:0] row_count,
  input  logic       q_full,
  output logic       push,
  output job_t       push_job
);

  logic       backlight_r;
  logic       backlight_nxt;
  logic [2:0] rows_eff;
  logic [1:0] row_sel;
  logic [7:0] cursor_sum;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    if (row_count == 3'd0) begin
      rows_eff = 3'd1;
    end else if (row_count > 3'(MAX_ROWS)) begin
      rows_eff = 3'(MAX_ROWS);
    end else begin
      rows_eff = row_count;
    end
    if (in_row >= {5'd0, rows_eff}) begin
      row_sel = 2'(rows_eff - 3'd1);
    end else begin
      row_sel = in_row[1:0];
    end
    cursor_sum = in_column + row_base(row_sel);
  end

  always_comb begin
    backlight_nxt      = backlight_r;
    push_job.kind      = JOB_LCD;
    push_job.value     = in_value;
    push_job.rs        = 1'b0;
    push_job.tail_wait = 1'b0;
    case (op_t'(in_opcode))
      OP_INIT: begin
        backlight_nxt = 1'b1;
        push_job.kind = JOB_INIT;
      end
      OP_COMMAND: begin
      end
      OP_DATA: begin
        push_job.rs = 1'b1;
      end
      OP_CURSOR: begin
        push_job.value = CMD_SET_DDRAM | cursor_sum;
      end
      OP_CLEAR: begin
        push_job.value     = CMD_CLEAR;
        push_job.tail_wait = 1'b1;
      end
      OP_HOME: begin
        push_job.value     = CMD_HOME;
        push_job.tail_wait = 1'b1;
      end
      OP_LIGHT_ON: begin
        backlight_nxt = 1'b1;
        push_job.kind = JOB_SINGLE;
      end
      default: begin
        backlight_nxt = 1'b0;
        push_job.kind = JOB_SINGLE;
      end
    endcase
    push_job.bl = backlight_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      backlight_r <= 1'b0;
    end else if (push) begin
      backlight_r <= backlight_nxt;
    end
  end

endmodule

// ===== hdl/lcdx_queue.sv =====
`timescale 1ns / 1ps
module lcdx_queue import lcdx_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : AW'(p + 1'b1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= CW'(count_r + 1'b1);
      end else if (pop && !push) begin
        count_r <= CW'(count_r - 1'b1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue popped while empty");

endmodule

// ===== hdl/lcdx_back.sv =====
`timescale 1ns / 1ps
module lcdx_back import lcdx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  job_t       head,
  input  logic       q_empty,
  output logic       q_pop,
  input  logic [6:0] expander_address,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_bus_address,
  output logic [7:0] out_expander_byte,
  output logic [5:0] out_wait_before_ms,
  output logic [2:0] out_wait_after_ms,
  output logic       out_last
);

  logic [2:0] step_r, step_nxt;
  logic [2:0] cmd_r, cmd_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] bus_address_r;
  logic [7:0] byte_r;
  logic [5:0] wait_before_r;
  logic [2:0] wait_after_r;
  logic       last_r;

  logic       is_init;
  logic       is_single;
  logic [7:0] cur_val;
  logic [3:0] nib;
  logic       en;
  logic       step_end;
  logic       item_done;
  logic [7:0] byte_c;
  logic [5:0] wait_before_c;
  logic [2:0] wait_after_c;
  logic       adv;
  logic       fire;

  assign is_init   = (head.kind == JOB_INIT);
  assign is_single = (head.kind == JOB_SINGLE);
  assign cur_val   = is_init ? init_cmd(cmd_r) : head.value;
  assign step_end  = (step_r == LAST_STEP);
  assign item_done = is_single || (step_end && (!is_init || cmd_r == LAST_INIT_CMD));

  always_comb begin
    // high nibble for the first three bytes, low nibble for the rest
    nib = (step_r < 3'd3) ? cur_val[7:4] : cur_val[3:0];
    en  = (step_r == 3'd1) || (step_r == 3'd4);
    if (is_single) begin
      byte_c = head.bl ? BL_BIT : 8'h00;
    end else begin
      byte_c = {nib, 4'h0} | (head.bl ? BL_BIT : 8'h00) | (en ? EN_BIT : 8'h00)
             | (head.rs ? RS_BIT : 8'h00);
    end
    wait_before_c = (is_init && cmd_r == 3'd0 && step_r == 3'd0) ? WAIT_POWER_MS : 6'd0;
    if (!is_single && step_end && (is_init ? (cmd_r != LAST_INIT_CMD) : head.tail_wait)) begin
      wait_after_c = WAIT_CMD_MS;
    end else begin
      wait_after_c = 3'd0;
    end
  end

  assign adv   = !out_valid_r || !out_stall;
  assign fire  = adv && !q_empty;
  assign q_pop = fire && item_done;

  always_comb begin
    step_nxt      = step_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      if (item_done) begin
        step_nxt = 3'd0;
        cmd_nxt  = 3'd0;
      end else if (step_end) begin
        step_nxt = 3'd0;
        cmd_nxt  = cmd_r + 3'd1;
      end else begin
        step_nxt = step_r + 3'd1;
      end
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= 3'd0;
      cmd_r       <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      cmd_r       <= cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      bus_address_r <= {expander_address, 1'b0};
      byte_r        <= byte_c;
      wait_before_r <= wait_before_c;
      wait_after_r  <= wait_after_c;
      last_r        <= item_done;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bus_address    = bus_address_r;
  assign out_expander_byte  = byte_r;
  assign out_wait_before_ms = wait_before_r;
  assign out_wait_after_ms  = wait_after_r;
  assign out_last           = last_r;

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= LAST_STEP)
    else $error("byte step out of range");

  a_cmd_only_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r != 3'd0) |-> (!q_empty && head.kind == JOB_INIT && cmd_r <= LAST_INIT_CMD))
    else $error("init command index outside an init job");

  a_step_holds_job: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r != 3'd0) |-> (!q_empty && head.kind != JOB_SINGLE))
    else $error("mid-sequence step without a multi-byte job");

  a_pop_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_last))
    else $error("job retired without a last word");

endmodule

// ===== hdl/char_lcd_expander_byte_sequencer_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// in_     | input     | in_valid/in_stall  | opcode, value, column, row
// out_    | output    | out_valid/out_stall| bus_address, expander_byte, waits, last
// cfg_    | input     | APB psel/penable   | expander_address (0x0), row_count (0x4)
//
// One expander word leaves per cycle while a job is queued and out_stall is low: an LCD byte
// is six words, init 36, a backlight request one; the single output word register of the back end sets this.
// The front accepts a request per cycle until the job queue (QUEUE_DEPTH) fills.
// Reset (rst_n low, synchronous) empties the queue and clears the backlight bit.
// An output word stalled by out_stall holds; the queue keeps taking requests.
module char_lcd_expander_byte_sequencer_unit import lcdx_pkg::*; #(
  parameter int MAX_ROWS    = MAX_ROWS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_opcode,
  input  logic [7:0]  in_value,
  input  logic [7:0]  in_column,
  input  logic [7:0]  in_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_bus_address,
  output logic [7:0]  out_expander_byte,
  output logic [5:0]  out_wait_before_ms,
  output logic [2:0]  out_wait_after_ms,
  output logic        out_last,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [6:0] exp_addr_r;
  logic [2:0] row_count_r;
  logic       cfg_wr;
  reg_idx_t   cfg_idx;

  logic       push;
  job_t       push_job;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  job_t       head;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_addr_r  <= EXP_ADDR_RST;
      row_count_r <= ROW_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_EXP_ADDR:  exp_addr_r  <= cfg_pwdata[6:0];
        REG_ROW_COUNT: row_count_r <= cfg_pwdata[2:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_EXP_ADDR:  cfg_prdata = {25'd0, exp_addr_r};
      REG_ROW_COUNT: cfg_prdata = {29'd0, row_count_r};
      default:       cfg_prdata = 32'd0;
    endcase
  end

  lcdx_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_value  (in_value),
    .in_column (in_column),
    .in_row    (in_row),
    .row_count (row_count_r),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  lcdx_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head)
  );

  lcdx_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .head               (head),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .expander_address   (exp_addr_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bus_address    (out_bus_address),
    .out_expander_byte  (out_expander_byte),
    .out_wait_before_ms (out_wait_before_ms),
    .out_wait_after_ms  (out_wait_after_ms),
    .out_last           (out_last)
  );

endmodule

// ===== tb/char_lcd_expander_byte_sequencer_unit_tb.sv =====
`timescale 1ns / 1ps
module char_lcd_expander_byte_sequencer_unit_tb;
  import lcdx_pkg::*;

  typedef struct packed {
    logic [7:0] bus_address;
    logic [7:0] expander_byte;
    logic [5:0] wait_before_ms;
    logic [2:0] wait_after_ms;
    logic       is_last;
  } exp_word_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic [7:0] column;
    logic [7:0] row;
    logic       typed;
    exp_word_t  word;
  } req_row_t;

  localparam int ROW_LIMIT   = MAX_ROWS_DEF;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 8;
  localparam int END_TAIL    = 50;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 20;
  localparam int DIR_ROWS    = 20;

  localparam logic [47:0] INIT_CMDS    = 48'h33_32_28_0C_01_06;
  localparam logic [31:0] LINE_OFFSETS = 32'h00_40_14_54;

  localparam exp_word_t NO_WORD   = '0;
  localparam exp_word_t LIT_WORD  = '{8'h4E, 8'h08, 6'd0, 3'd0, 1'b1};
  localparam exp_word_t DARK_WORD = '{8'h4E, 8'h00, 6'd0, 3'd0, 1'b1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_opcode = '0;
  logic [7:0]  in_value = '0;
  logic [7:0]  in_column = '0;
  logic [7:0]  in_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_bus_address;
  logic [7:0]  out_expander_byte;
  logic [5:0]  out_wait_before_ms;
  logic [2:0]  out_wait_after_ms;
  logic        out_last;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // predictor state
  logic [6:0]  model_exp_addr = EXP_ADDR_RST;
  logic [2:0]  model_row_count = ROW_COUNT_RST;
  logic        model_backlight = 1'b0;
  exp_word_t   expected_words[$];

  int          failures = 0;
  int          quiet_cycles = 0;
  bit          idle_on = 1'b1;
  int          stall_left = 0;
  int          free_left = 0;

  req_row_t directed_reqs [DIR_ROWS] = '{
    '{OP_DATA,      8'hA5, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_LIGHT_ON,  8'h00, 8'h00, 8'h00, 1'b1, LIT_WORD},
    '{OP_LIGHT_OFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, DARK_WORD},
    '{OP_COMMAND,   8'h5A, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_INIT,      8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WORD},
    '{OP_COMMAND,   8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_COMMAND,   8'hFF, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_DATA,      8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_DATA,      8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WORD},
    '{OP_CURSOR,    8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_CURSOR,    8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WORD},
    '{OP_CURSOR,    8'h00, 8'hC0, 8'h01, 1'b0, NO_WORD},
    '{OP_CURSOR,    8'h00, 8'h05, 8'h02, 1'b0, NO_WORD},
    '{OP_CLEAR,     8'hFF, 8'hFF, 8'hFF, 1'b0, NO_WORD},
    '{OP_HOME,      8'hFF, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_LIGHT_OFF, 8'h00, 8'h00, 8'h00, 1'b1, DARK_WORD},
    '{OP_DATA,      8'h3C, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_LIGHT_ON,  8'hFF, 8'hFF, 8'hFF, 1'b1, LIT_WORD},
    '{OP_INIT,      8'h00, 8'h00, 8'h00, 1'b0, NO_WORD},
    '{OP_CURSOR,    8'h00, 8'h80, 8'h80, 1'b0, NO_WORD}
  };

  char_lcd_expander_byte_sequencer_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_value           (in_value),
    .in_column          (in_column),
    .in_row             (in_row),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bus_address    (out_bus_address),
    .out_expander_byte  (out_expander_byte),
    .out_wait_before_ms (out_wait_before_ms),
    .out_wait_after_ms  (out_wait_after_ms),
    .out_last           (out_last),
    .cfg_psel           (cfg_psel),
    .cfg_penable        (cfg_penable),
    .cfg_pwrite         (cfg_pwrite),
    .cfg_paddr          (cfg_paddr),
    .cfg_pwdata         (cfg_pwdata),
    .cfg_prdata         (cfg_prdata),
    .cfg_pready         (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void queue_expander_word(input logic [7:0] b, input logic [5:0] lead_wait,
                                              input logic [2:0] tail_wait, input logic ends_req);
    expected_words.push_back('{{model_exp_addr, 1'b0}, b, lead_wait, tail_wait, ends_req});
  endfunction

  // high nibble then low nibble, each as enable low, high, low
  function automatic void queue_lcd_byte(input logic [7:0] lcd_byte, input logic rs,
                                         input logic [5:0] lead_wait,
                                         input logic [2:0] tail_wait, input logic ends_req);
    logic [7:0] b;
    int step;
    for (step = 0; step < 6; step++) begin
      b = {(step < 3) ? lcd_byte[7:4] : lcd_byte[3:0], 4'h0};
      if (model_backlight) b |= BL_BIT;
      if (rs) b |= RS_BIT;
      if (step == 1 || step == 4) b |= EN_BIT;
      queue_expander_word(b, (step == 0) ? lead_wait : 6'd0,
                          (step == 5) ? tail_wait : 3'd0, (step == 5) && ends_req);
    end
  endfunction

  function automatic void expand_request(input op_t op, input logic [7:0] value,
                                         input logic [7:0] column, input logic [7:0] row);
    int eff_rows;
    int line;
    int i;
    logic [7:0] ddram;
    case (op)
      OP_INIT: begin
        model_backlight = 1'b1;
        for (i = 0; i < 6; i++)
          queue_lcd_byte(INIT_CMDS[8*(5-i) +: 8], 1'b0, (i == 0) ? WAIT_POWER_MS : 6'd0,
                         (i < 5) ? WAIT_CMD_MS : 3'd0, i == 5);
      end
      OP_COMMAND: queue_lcd_byte(value, 1'b0, 6'd0, 3'd0, 1'b1);
      OP_DATA:    queue_lcd_byte(value, 1'b1, 6'd0, 3'd0, 1'b1);
      OP_CURSOR: begin
        eff_rows = model_row_count;
        if (eff_rows == 0) eff_rows = 1;
        if (eff_rows > ROW_LIMIT) eff_rows = ROW_LIMIT;
        line = (row >= eff_rows) ? eff_rows - 1 : row;
        ddram = column + LINE_OFFSETS[8*(3-line) +: 8];
        queue_lcd_byte(CMD_SET_DDRAM | ddram, 1'b0, 6'd0, 3'd0, 1'b1);
      end
      OP_CLEAR: queue_lcd_byte(CMD_CLEAR, 1'b0, 6'd0, WAIT_CMD_MS, 1'b1);
      OP_HOME:  queue_lcd_byte(CMD_HOME, 1'b0, 6'd0, WAIT_CMD_MS, 1'b1);
      OP_LIGHT_ON: begin
        model_backlight = 1'b1;
        queue_expander_word(BL_BIT, 6'd0, 3'd0, 1'b1);
      end
      default: begin
        model_backlight = 1'b0;
        queue_expander_word(8'h00, 6'd0, 3'd0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      failures++;
    end
  endfunction

  // called and returns on a rising edge; valid stays up for the next request
  task automatic send_req(input op_t op, input logic [7:0] value, input logic [7:0] column,
                          input logic [7:0] row);
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_value  <= value;
    in_column <= column;
    in_row    <= row;
    do @(negedge clk); while (in_stall);
    expand_request(op, value, column, row);
    @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_EXP_ADDR) model_exp_addr = data[6:0];
    else model_row_count = data[2:0];
    @(posedge clk);
  endtask

  // receiver stalls in bursts, free runs in between
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      free_left  = 0;
    end else begin
      if (stall_left == 0 && free_left == 0) begin
        if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 11);
        else free_left = $urandom_range(1, 24);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        free_left--;
      end
    end
  end

  exp_word_t want;

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, actual byte 0x%0h",
                   $time, out_expander_byte);
          failures++;
        end else begin
          want = expected_words.pop_front();
          check_field("bus_address", want.bus_address, out_bus_address);
          check_field("expander_byte", want.expander_byte, out_expander_byte);
          check_field("wait_before_ms", {2'b00, want.wait_before_ms},
                      {2'b00, out_wait_before_ms});
          check_field("wait_after_ms", {5'd0, want.wait_after_ms}, {5'd0, out_wait_after_ms});
          check_field("last", {7'd0, want.is_last}, {7'd0, out_last});
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, quiet_cycles);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [6:0] ph_addr [PHASES];
    logic [2:0] ph_rows [PHASES];
    bit         ph_idle [PHASES];
    int         pick;
    op_t        op;
    logic [7:0] row;

    ph_addr[0] = 7'd0;
    ph_addr[1] = 7'd127;
    ph_addr[2] = 7'($urandom_range(1, 126));
    ph_addr[3] = 7'($urandom_range(1, 126));
    ph_addr[4] = 7'($urandom_range(1, 126));
    ph_rows[0] = 3'd1;
    ph_rows[1] = 3'd4;
    ph_rows[2] = 3'd0;
    ph_rows[3] = 3'd7;
    ph_rows[4] = 3'd3;
    ph_idle[0] = 1'b1;
    ph_idle[1] = 1'b0;
    ph_idle[2] = 1'b1;
    ph_idle[3] = 1'b1;
    ph_idle[4] = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed pass on reset settings
    for (int i = 0; i < DIR_ROWS; i++) begin
      if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 11));
      send_req(directed_reqs[i].op, directed_reqs[i].value, directed_reqs[i].column,
               directed_reqs[i].row);
      if (directed_reqs[i].typed) begin
        void'(expected_words.pop_back());
        expected_words.push_back(directed_reqs[i].word);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_reg(REG_EXP_ADDR, {25'd0, ph_addr[p]});
      write_reg(REG_ROW_COUNT, {29'd0, ph_rows[p]});
      idle_on = ph_idle[p];
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold the next request until the sequencer has emptied, or else sometimes pause the sender
        if ((p == 2 && k == 12) || (idle_on && $urandom_range(0, 15) == 0))
          wait_drained();
        else if (idle_on && $urandom_range(0, 3) == 0)
          pause_sender($urandom_range(1, 11));
        pick = $urandom_range(0, 15);
        if (pick == 0) op = OP_INIT;
        else if (pick <= 3) op = OP_COMMAND;
        else if (pick <= 6) op = OP_DATA;
        else if (pick <= 10) op = OP_CURSOR;
        else if (pick == 11) op = OP_CLEAR;
        else if (pick == 12) op = OP_HOME;
        else if (pick == 13) op = OP_LIGHT_ON;
        else if (pick == 14) op = OP_LIGHT_OFF;
        else op = op_t'($urandom_range(0, 7));
        row = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
        send_req(op, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), row);
      end
    end

    wait_drained();
    repeat (END_TAIL) @(posedge clk);
    if (failures == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== char_lcd_expander_byte_sequencer_unit.f =====
hdl/lcdx_pkg.sv
hdl/lcdx_front.sv
hdl/lcdx_queue.sv
hdl/lcdx_back.sv
hdl/char_lcd_expander_byte_sequencer_unit.sv
tb/char_lcd_expander_byte_sequencer_unit_tb.sv
